### rtl/fihp_pkg.sv
// Package for the floppy image header parser: record type, record and error codes,
// header constants and the signature table. No dependencies.
`default_nettype none
package fihp_pkg;

	localparam int unsigned POS_W        = 26;
	localparam int unsigned HEADER_BYTES = 512;
	localparam int unsigned MAX_TRACKS   = 84;
	localparam int unsigned MAX_SIDES    = 2;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	// record kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PRESENT = 2'd1;
	localparam logic [1:0] KIND_ABSENT  = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	// error codes
	localparam logic [1:0] ERR_SIGNATURE = 2'd0;
	localparam logic [1:0] ERR_TRACKS    = 2'd1;
	localparam logic [1:0] ERR_SIDES     = 2'd2;
	localparam logic [1:0] ERR_BOUNDS    = 2'd3;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [1:0]  status;
		logic [6:0]  track_count;
		logic [1:0]  side_count;
		logic [7:0]  enc_mode;
		logic [7:0]  drive_iface;
		logic [15:0] rate_kbps;
		logic [15:0] rpm;
		logic [6:0]  track_index;
		logic [15:0] track_offset;
		logic [15:0] track_len;
		logic [22:0] total_bytes;
	} rec_t;

	// signature "HXCPICFE", byte 0 first
	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = 8'h48;
			3'd1: r = 8'h58;
			3'd2: r = 8'h43;
			3'd3: r = 8'h50;
			3'd4: r = 8'h49;
			3'd5: r = 8'h43;
			3'd6: r = 8'h46;
			default: r = 8'h45;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/floppy_image_header_parser_core.sv
// Top level of the floppy image header parser: byte parser, output register and skid stage.
// Depends on fihp_pkg.
`default_nettype none
// Usage
//   Input channel (in_valid/in_ready): one image byte per beat, with start_of_image set
//   on byte 0 of each image; it restarts the parse from a clean state.
//   Output channel (out_valid/out_ready): zero or one record per input beat: a header
//   record after byte 19, one track record per 4-byte track list entry, or one error
//   record, after which bytes are dropped until the next start_of_image.
//   Config channel (cfg_valid/cfg_ready): writes image_size; always ready. Write it
//   only while the parser is idle.
//   A record is registered into the output register, or into the skid entry if that stalls.
//   Throughput: one byte per cycle while in_ready is high. Each byte goes through one pass
//   of compares, one small multiply (list block times block size, split over bytes 18 and
//   19) and one add into the state and output registers.
//   Stall: an output register plus one skid entry hold records; in_ready is registered
//   and drops only when both are full, so bytes keep flowing while a record waits.
//   Reset: asynchronous, active low; clears image_size, the parse state (next byte is
//   taken as byte 0) and both output entries.
module floppy_image_header_parser_core #(
	parameter int unsigned BLOCK_BYTES = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [25:0] cfg_data,
	// input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        start_of_image,
	// output channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       record_kind,
	output logic [1:0]       status,
	output logic [6:0]       track_count,
	output logic [1:0]       side_count,
	output logic [7:0]       enc_mode,
	output logic [7:0]       drive_iface,
	output logic [15:0]      rate_kbps,
	output logic [15:0]      rpm,
	output logic [6:0]       track_index,
	output logic [15:0]      track_offset,
	output logic [15:0]      track_len,
	output logic [22:0]      total_bytes
);
	import fihp_pkg::*;

	localparam int unsigned BW      = $clog2(BLOCK_BYTES + 1);
	localparam int unsigned PRODW   = 8 + BW;           // byte times block size
	localparam int unsigned START_W = 16 + BW;          // list start in bytes
	localparam int unsigned LOB_W   = PRODW + 1;        // low product plus list size
	localparam int unsigned BND_W   = START_W + 1;      // list end in bytes
	localparam int unsigned CMP_W   = (START_W > POS_W) ? START_W : POS_W;
	localparam int unsigned CMPB_W  = (BND_W > POS_W) ? BND_W : POS_W;
	localparam logic [PRODW-1:0] BB_V = PRODW'(BLOCK_BYTES);

	// parse phases
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_SEEK   = 2'd1;
	localparam logic [1:0] PH_LIST   = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	// configuration
	logic [POS_W-1:0]   image_size_q;

	// parse state
	logic [1:0]         phase_q;
	logic [POS_W-1:0]   pos_q;
	logic [6:0]         tracks_q;
	logic [1:0]         sides_q;
	logic [7:0]         enc_q;
	logic [7:0]         iface_q;
	logic [15:0]        rate_q;
	logic [15:0]        speed_q;
	logic [7:0]         lb_lo_q;     // low byte of the list block
	logic [PRODW-1:0]   lo_prod_q;   // low byte times block size
	logic [LOB_W-1:0]   bound_lo_q;  // low product plus list length
	logic [START_W-1:0] start_q;
	logic [23:0]        entry_q;
	logic [1:0]         sub_q;
	logic [6:0]         cnt_q;
	logic [22:0]        sum_q;

	// output register and skid entry
	rec_t               out_q;
	logic               out_valid_q;
	rec_t               skid_q;
	logic               skid_valid_q;

	// next-state values
	logic [1:0]         phase_n;
	logic [POS_W-1:0]   pos_n;
	logic [6:0]         tracks_n;
	logic [1:0]         sides_n;
	logic [7:0]         enc_n;
	logic [7:0]         iface_n;
	logic [15:0]        rate_n;
	logic [15:0]        speed_n;
	logic [7:0]         lb_lo_n;
	logic [PRODW-1:0]   lo_prod_n;
	logic [LOB_W-1:0]   bound_lo_n;
	logic [START_W-1:0] start_n;
	logic [23:0]        entry_n;
	logic [1:0]         sub_n;
	logic [6:0]         cnt_n;
	logic [22:0]        sum_n;
	rec_t               rec;
	logic               has_rec;

	// effective state after an optional restart
	logic [1:0]         ph_e;
	logic [POS_W-1:0]   pos_e;
	logic [6:0]         tracks_e;
	logic [1:0]         sides_e;
	logic [7:0]         enc_e;
	logic [7:0]         iface_e;
	logic [15:0]        rate_e;
	logic [15:0]        speed_e;
	logic [6:0]         cnt_e;
	logic [22:0]        sum_e;

	logic [PRODW-1:0]   byte_prod;
	logic [START_W-1:0] start_w;
	logic [BND_W-1:0]   bound_w;
	logic               list_go;
	logic [1:0]         sub_use;
	logic [15:0]        len_w;
	logic [15:0]        off_w;
	logic [6:0]         cnt_inc;

	logic in_fire;
	logic out_fire;

	assign cfg_ready = 1'b1;
	assign in_ready  = ~skid_valid_q;
	assign in_fire   = in_valid & in_ready;
	assign out_fire  = out_valid_q & out_ready;

	always_comb begin
		ph_e     = start_of_image ? PH_HEADER : phase_q;
		pos_e    = start_of_image ? '0 : pos_q;
		tracks_e = start_of_image ? '0 : tracks_q;
		sides_e  = start_of_image ? '0 : sides_q;
		enc_e    = start_of_image ? '0 : enc_q;
		iface_e  = start_of_image ? '0 : iface_q;
		rate_e   = start_of_image ? '0 : rate_q;
		speed_e  = start_of_image ? '0 : speed_q;
		cnt_e    = start_of_image ? '0 : cnt_q;
		sum_e    = start_of_image ? '0 : sum_q;

		byte_prod = PRODW'(data_byte) * BB_V;
		start_w   = START_W'({byte_prod, 8'h00}) + START_W'(lo_prod_q);
		bound_w   = BND_W'({byte_prod, 8'h00}) + BND_W'(bound_lo_q);

		list_go = (ph_e == PH_LIST) ||
			((ph_e == PH_SEEK) && (CMP_W'(pos_e) == CMP_W'(start_q)));
		sub_use = (ph_e == PH_LIST) ? sub_q : 2'd0;
		off_w   = entry_q[15:0];
		len_w   = {data_byte, entry_q[23:16]};
		cnt_inc = cnt_e + 7'd1;

		// hold by default
		phase_n    = ph_e;
		pos_n      = (pos_e == POS_MAX) ? pos_e : pos_e + POS_W'(1);
		tracks_n   = tracks_e;
		sides_n    = sides_e;
		enc_n      = enc_e;
		iface_n    = iface_e;
		rate_n     = rate_e;
		speed_n    = speed_e;
		lb_lo_n    = lb_lo_q;
		lo_prod_n  = lo_prod_q;
		bound_lo_n = bound_lo_q;
		start_n    = start_q;
		entry_n    = entry_q;
		sub_n      = sub_q;
		cnt_n      = cnt_e;
		sum_n      = sum_e;
		has_rec    = 1'b0;

		rec             = '0;
		rec.track_count = tracks_e;
		rec.side_count  = sides_e;
		rec.enc_mode    = enc_e;
		rec.drive_iface = iface_e;
		rec.rate_kbps   = rate_e;
		rec.rpm         = speed_e;

		if (ph_e == PH_HEADER) begin
			if (pos_e < POS_W'(8)) begin
				if (((pos_e == '0) && (image_size_q < POS_W'(HEADER_BYTES))) ||
						(data_byte != sig_byte(pos_e[2:0]))) begin
					has_rec = 1'b1;
					rec.record_kind = KIND_ERROR;
					rec.status = ERR_SIGNATURE;
					phase_n = PH_DONE;
				end
			end else if (pos_e == POS_W'(9)) begin
				if (data_byte > 8'(MAX_TRACKS)) begin
					has_rec = 1'b1;
					rec.record_kind = KIND_ERROR;
					rec.status = ERR_TRACKS;
					phase_n = PH_DONE;
				end else begin
					tracks_n = data_byte[6:0];
				end
			end else if (pos_e == POS_W'(10)) begin
				if (data_byte > 8'(MAX_SIDES)) begin
					has_rec = 1'b1;
					rec.record_kind = KIND_ERROR;
					rec.status = ERR_SIDES;
					phase_n = PH_DONE;
				end else begin
					sides_n = data_byte[1:0];
				end
			end else if (pos_e == POS_W'(11)) begin
				enc_n = data_byte;
			end else if (pos_e == POS_W'(12)) begin
				rate_n[7:0] = data_byte;
			end else if (pos_e == POS_W'(13)) begin
				rate_n[15:8] = data_byte;
			end else if (pos_e == POS_W'(14)) begin
				speed_n[7:0] = data_byte;
			end else if (pos_e == POS_W'(15)) begin
				speed_n[15:8] = data_byte;
			end else if (pos_e == POS_W'(16)) begin
				iface_n = data_byte;
			end else if (pos_e == POS_W'(18)) begin
				// low half of the list start, plus the list length
				lb_lo_n    = data_byte;
				lo_prod_n  = byte_prod;
				bound_lo_n = LOB_W'(byte_prod) + LOB_W'({tracks_e, 2'b00});
			end else if (pos_e == POS_W'(19)) begin
				has_rec = 1'b1;
				start_n = start_w;
				if (((data_byte == 8'h00) && (lb_lo_q == 8'h00)) ||
						(CMPB_W'(bound_w) > CMPB_W'(image_size_q))) begin
					rec.record_kind = KIND_ERROR;
					rec.status = ERR_BOUNDS;
					phase_n = PH_DONE;
				end else begin
					rec.record_kind = KIND_HEADER;
					phase_n = (tracks_e == '0) ? PH_DONE : PH_SEEK;
				end
			end
		end else if (list_go) begin
			phase_n = PH_LIST;
			sub_n   = sub_use + 2'd1;
			case (sub_use)
				2'd0: entry_n = {16'h0000, data_byte};
				2'd1: entry_n[15:8] = data_byte;
				2'd2: entry_n[23:16] = data_byte;
				default: begin
					has_rec = 1'b1;
					sum_n = sum_e + 23'(len_w);
					rec.record_kind = (off_w != '0) ? KIND_PRESENT : KIND_ABSENT;
					rec.track_index = cnt_e;
					rec.track_offset = off_w;
					rec.track_len = len_w;
					rec.total_bytes = sum_e + 23'(len_w);
					cnt_n = cnt_inc;
					if (cnt_inc >= tracks_e) begin
						phase_n = PH_DONE;
					end
				end
			endcase
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			image_size_q <= cfg_data;
		end
	end

	// parse state, advanced once per accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			tracks_q <= '0;
			sides_q <= '0;
			enc_q   <= '0;
			iface_q <= '0;
			rate_q  <= '0;
			speed_q <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			sub_q   <= '0;
		end else if (in_fire) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			tracks_q <= tracks_n;
			sides_q <= sides_n;
			enc_q   <= enc_n;
			iface_q <= iface_n;
			rate_q  <= rate_n;
			speed_q <= speed_n;
			cnt_q   <= cnt_n;
			sum_q   <= sum_n;
			sub_q   <= sub_n;
		end
	end

	// list start and entry bytes: always written before they are read
	always_ff @(posedge clk) begin
		if (in_fire) begin
			lb_lo_q    <= lb_lo_n;
			lo_prod_q  <= lo_prod_n;
			bound_lo_q <= bound_lo_n;
			start_q    <= start_n;
			entry_q    <= entry_n;
		end
	end

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_fire && has_rec) begin
			if (out_valid_q && !out_ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (in_fire && has_rec) begin
			if (out_valid_q && !out_ready) begin
				skid_q <= rec;
			end else begin
				out_q <= rec;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign record_kind  = out_q.record_kind;
	assign status       = out_q.status;
	assign track_count  = out_q.track_count;
	assign side_count   = out_q.side_count;
	assign enc_mode     = out_q.enc_mode;
	assign drive_iface  = out_q.drive_iface;
	assign rate_kbps    = out_q.rate_kbps;
	assign rpm          = out_q.rpm;
	assign track_index  = out_q.track_index;
	assign track_offset = out_q.track_offset;
	assign track_len    = out_q.track_len;
	assign total_bytes  = out_q.total_bytes;

endmodule
`default_nettype wire
